[rtl/core/wbps_pkg.sv]
// Package for the wildcard byte pattern scanner.
// Sizes, the register index codes, the configuration bundle and the skip function.
// No dependencies.
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN = 24;
  localparam int COUNT_BITS  = 32;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PAT_LOW   = 3'd0,
    CFG_PAT_MID   = 3'd1,
    CFG_PAT_HIGH  = 3'd2,
    CFG_WILD_MASK = 3'd3,
    CFG_PAT_LEN   = 3'd4,
    CFG_BASE      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [MAX_PATTERN-1:0]      wild;
    logic [LEN_BITS-1:0]         len;
    logic [ADDR_BITS-1:0]        base;
    logic [LEN_BITS-1:0]         skip;
  } wbps_cfg_t;

  // Index just past the lowest run of set bits; 0 when no bit is set.
  function automatic logic [LEN_BITS-1:0] run_end(input logic [MAX_PATTERN-1:0] used);
    logic [MAX_PATTERN:0]   x;
    logic [MAX_PATTERN:0]   y;
    logic [MAX_PATTERN:0]   z;
    logic [LEN_BITS-1:0]    pos;
    x   = {1'b0, used};
    y   = x + (x & (~x + 1'b1));
    z   = y & ~x;
    pos = '0;
    for (int i = MAX_PATTERN; i >= 0; i--) begin
      if (z[i]) begin
        pos = LEN_BITS'(i);
      end
    end
    if (used == '0) begin
      pos = '0;
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wbps_cfg_regs.sv]
// Configuration registers of the scanner and the values derived from them.
// Depends on wbps_pkg.
`default_nettype none

module wbps_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wbps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output wbps_pkg::wbps_cfg_t                     cfg
);
  import wbps_pkg::*;

  logic [63:0]            pat_low_r, pat_mid_r, pat_high_r;
  logic [MAX_PATTERN-1:0] wild_r;
  logic [4:0]             len_r;
  logic [ADDR_BITS-1:0]   base_r;
  logic [LEN_BITS-1:0]    len_used;
  logic [MAX_PATTERN-1:0] wild_used;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
      wild_r     <= '0;
      len_r      <= 5'd1;
      base_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_LOW:   pat_low_r  <= cfg_data;
        CFG_PAT_MID:   pat_mid_r  <= cfg_data;
        CFG_PAT_HIGH:  pat_high_r <= cfg_data;
        CFG_WILD_MASK: wild_r     <= cfg_data[MAX_PATTERN-1:0];
        CFG_PAT_LEN:   len_r      <= cfg_data[4:0];
        CFG_BASE:      base_r     <= cfg_data[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length to 1..MAX_PATTERN
  always_comb begin
    if (len_r == 5'd0) begin
      len_used = LEN_BITS'(1);
    end else if (len_r > 5'(MAX_PATTERN)) begin
      len_used = LEN_BITS'(MAX_PATTERN);
    end else begin
      len_used = LEN_BITS'(len_r);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      wild_used[j] = wild_r[j] && (j < int'(len_used));
    end
  end

  assign cfg.pattern = {pat_high_r, pat_mid_r, pat_low_r};
  assign cfg.wild    = wild_r;
  assign cfg.len     = len_used;
  assign cfg.base    = base_r;
  assign cfg.skip    = run_end(wild_used);

endmodule

`default_nettype wire

[rtl/core/wbps_cell.sv]
// One window cell: holds one byte, passes it to the next cell, compares the incoming byte.
// Depends on nothing.
`default_nettype none

module wbps_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic       clear,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pat_byte,
  input  wire logic       care,
  output logic [7:0]      byte_out,
  output logic            hit
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (clear) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // Compare the byte this cell will hold after the shift
  assign hit      = !care || (byte_in == pat_byte);
  assign byte_out = byte_r;

endmodule

`default_nettype wire

[rtl/core/wildcard_byte_pattern_scanner_core.sv]
// Top level of the wildcard byte pattern scanner: cell chain, counters, result pipeline.
// Depends on wbps_pkg, wbps_cfg_regs and wbps_cell.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata = data_byte, in_tlast = last_byte
//  out_    | out | out_tvalid/out_tready | out_tdata = match_address, out_tuser = match_found
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One byte per cycle while in_tready is high; the cell row compares every position in parallel.
// A region's result is registered in stage A at its last byte, then in stage B with the address add.
// Reset is synchronous and clears the window, counters and result valid flags.
// in_tready drops only while both result stages are full and out_tready is low.
`default_nettype none

module wildcard_byte_pattern_scanner_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  wire logic                               in_tlast,   // last_byte
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [wbps_pkg::ADDR_BITS-1:0]          out_tdata,  // [47:0] match_address
  output logic                                    out_tuser,  // match_found
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wbps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import wbps_pkg::*;

  wbps_cfg_t cfg;

  logic                    in_xfer, last_xfer;
  logic [MAX_PATTERN-1:0]  hits;
  logic [MAX_PATTERN-1:0][7:0] win;
  logic [MAX_PATTERN-1:0][7:0] cell_in;

  logic [COUNT_BITS-1:0]   bytes_seen_r, bytes_seen_nxt;
  logic                    have_match_r, have_match_nxt;
  logic [COUNT_BITS-1:0]   first_start_r, first_start_nxt;
  logic [LEN_BITS-1:0]     len_m1;
  logic                    counted, new_match;
  logic [COUNT_BITS-1:0]   cand_start;

  logic                    pend_valid_r, pend_valid_nxt;
  logic                    pend_found_r, pend_found_nxt;
  logic [COUNT_BITS-1:0]   pend_start_r, pend_start_nxt;
  logic                    b_load;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [ADDR_BITS-1:0]    out_addr_r, out_addr_nxt;

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_xfer   = in_tvalid && in_tready;
  assign last_xfer = in_xfer && in_tlast;

  // Cell k holds window byte k (0 newest) and checks pattern position len-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_BITS-1:0] pos;
    logic                active;
    logic [7:0]          pbyte;
    logic                care;

    assign active = LEN_BITS'(k) < cfg.len;
    assign pos    = cfg.len - LEN_BITS'(1) - LEN_BITS'(k);
    assign pbyte  = active ? cfg.pattern[pos] : 8'h00;
    assign care   = active && !cfg.wild[pos];

    if (k == 0) begin : g_head
      assign cell_in[k] = in_tdata;
    end else begin : g_body
      assign cell_in[k] = win[k-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_xfer),
      .clear    (last_xfer),
      .byte_in  (cell_in[k]),
      .pat_byte (pbyte),
      .care     (care),
      .byte_out (win[k]),
      .hit      (hits[k])
    );
  end

  assign len_m1     = cfg.len - LEN_BITS'(1);
  assign counted    = bytes_seen_r != '1;
  assign cand_start = bytes_seen_r - COUNT_BITS'(len_m1);
  assign new_match  = counted && !have_match_r &&
                      (bytes_seen_r >= COUNT_BITS'(len_m1)) && (&hits);

  always_comb begin
    bytes_seen_nxt  = bytes_seen_r;
    have_match_nxt  = have_match_r;
    first_start_nxt = first_start_r;
    if (last_xfer) begin
      bytes_seen_nxt  = '0;
      have_match_nxt  = 1'b0;
      first_start_nxt = '0;
    end else if (in_xfer) begin
      if (counted) begin
        bytes_seen_nxt = bytes_seen_r + 1'b1;
      end
      if (new_match) begin
        have_match_nxt  = 1'b1;
        first_start_nxt = cand_start;
      end
    end
  end

  // Result stage A: found flag and match start, taken at the last byte
  assign b_load    = pend_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_valid_r || b_load;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_found_nxt = pend_found_r;
    pend_start_nxt = pend_start_r;
    if (last_xfer) begin
      pend_valid_nxt = 1'b1;
      pend_found_nxt = have_match_r || new_match;
      pend_start_nxt = have_match_r ? first_start_r : cand_start;
    end else if (b_load) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // Result stage B: final address, held until the transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (b_load) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = pend_found_r;
      out_addr_nxt  = pend_found_r ?
                      cfg.base + ADDR_BITS'(pend_start_r) + ADDR_BITS'(cfg.skip) : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= '0;
      have_match_r  <= 1'b0;
      first_start_r <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      bytes_seen_r  <= bytes_seen_nxt;
      have_match_r  <= have_match_nxt;
      first_start_r <= first_start_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_found_r <= pend_found_nxt;
    pend_start_r <= pend_start_nxt;
    out_found_r  <= out_found_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_found_r;

endmodule

`default_nettype wire

[rtl/core/wbps_checker.sv]
// Port-level checker for the scanner, attached to the top level by bind.
// Depends on wbps_pkg.
`default_nettype none

module wbps_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tlast,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [wbps_pkg::ADDR_BITS-1:0]     out_tdata,
  input wire logic                               out_tuser
);
  import wbps_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // No match reports address zero
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("address nonzero without a match");

  // A result only follows an earlier last-byte transfer or a stall
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2) ||
                          $past(!out_tready || !in_tready, 1))
    else $error("result without a last byte");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered out of reset");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for wildcard_byte_pattern_scanner_core: a directed table, then random
// regions under changing register settings, checked against table values or an in-bench scan model.
// Depends on wbps_pkg and the scanner RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int RANDOM_BYTES  = 1350;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_PHASE    = 3;
  localparam int MAX_SHOWN     = 10;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic [COUNT_BITS-1:0]   COUNT_SAT   = '1;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] value;
    logic [7:0]               data;
    logic                     last;
    logic                     typed;
    logic                     exp_found;
    logic [ADDR_BITS-1:0]     exp_addr;
  } script_row_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] addr;
  } scan_report_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = '0;   // [7:0] data_byte
  logic                     in_tlast   = 1'b0; // last_byte
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [ADDR_BITS-1:0]     out_tdata;         // [47:0] match_address
  logic                     out_tuser;         // match_found
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

  // Register copies and scan state of the model
  logic [CFG_DATA_BITS-1:0] pat_words [3];
  logic [MAX_PATTERN-1:0]   wild_bits;
  logic [LEN_BITS-1:0]      len_reg;
  logic [ADDR_BITS-1:0]     base_reg;
  logic [7:0]               window [MAX_PATTERN];
  logic [COUNT_BITS-1:0]    seen_count;
  logic                     match_held;
  logic [COUNT_BITS-1:0]    match_start;

  scan_report_t pending_reports [$];
  scan_report_t head_report;
  int           bytes_sent     = 0;
  int           reports_seen   = 0;
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  logic         hold_request   = 1'b0;

  script_row_t script [0:32] = '{
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h00, 1'b1, 1'b1, 1'b1, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'hFF, 1'b1, 1'b1, 1'b0, 48'h0},
    '{ROW_REG,  CFG_BASE,      64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_PAT_LOW,   64'h0000_0000_0042_3F41, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_WILD_MASK, 64'hFFFF_FFFF_FF00_0002, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_PAT_LEN,   64'd3,                   8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    // region shorter than the pattern
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h41, 1'b1, 1'b1, 1'b0, 48'h0},
    // match on the final start position, address wraps
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h41, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h99, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h42, 1'b1, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h41, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h7E, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h42, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h41, 1'b1, 1'b0, 1'b0, 48'h0},
    // zero length acts as one; wildcard bit past the length ignored
    '{ROW_REG,  CFG_PAT_LEN,   64'd0,                   8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h10, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h41, 1'b1, 1'b0, 1'b0, 48'h0},
    // all-wildcard pattern, oversized length clamps to the maximum
    '{ROW_REG,  CFG_WILD_MASK, 64'h0000_0000_00FF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_PAT_LEN,   64'd31,                  8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_BASE,      64'h0,                   8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h01, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h02, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h04, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h08, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h80, 1'b1, 1'b1, 1'b0, 48'h0},
    '{ROW_REG,  CFG_PAT_LEN,   64'd2,                   8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'hAA, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_BYTE, CFG_PAT_LOW,   64'h0,                   8'h55, 1'b1, 1'b1, 1'b1, 48'h2},
    '{ROW_REG,  CFG_PAT_MID,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_PAT_HIGH,  64'h8000_0000_0000_0001, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_SPARE_6,   64'hDEAD_BEEF_0123_4567, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0},
    '{ROW_REG,  CFG_SPARE_7,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 48'h0}
  };

  wildcard_byte_pattern_scanner_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_len();
    if (len_reg == '0) return 1;
    if (len_reg > MAX_PATTERN) return MAX_PATTERN;
    return int'(len_reg);
  endfunction

  function automatic logic [7:0] pat_byte(int j);
    return pat_words[j / 8][(j % 8) * 8 +: 8];
  endfunction

  // Index just past the first run of wildcards; 0 when none is in use
  function automatic int skip_after_wild(int len);
    int j;
    j = 0;
    while (j < len && !wild_bits[j]) j++;
    if (j >= len) return 0;
    while (j < len && wild_bits[j]) j++;
    return j;
  endfunction

  function automatic logic window_hit(int len);
    for (int j = 0; j < len; j++) begin
      if (!wild_bits[j] && window[len - 1 - j] != pat_byte(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    foreach (window[k]) window[k] = '0;
    seen_count  = '0;
    match_held  = 1'b0;
    match_start = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] value);
    unique case (idx)
      CFG_PAT_LOW:   pat_words[0] = value;
      CFG_PAT_MID:   pat_words[1] = value;
      CFG_PAT_HIGH:  pat_words[2] = value;
      CFG_WILD_MASK: wild_bits = value[MAX_PATTERN-1:0];
      CFG_PAT_LEN:   len_reg = value[LEN_BITS-1:0];
      CFG_BASE:      base_reg = value[ADDR_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advance the scan by one byte; returns 1 when the byte closes a region
  function automatic logic scan_byte(logic [7:0] data, logic last, output scan_report_t report);
    int len;
    len = eff_len();
    for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k - 1];
    window[0] = data;
    if (seen_count != COUNT_SAT) begin
      seen_count++;
      if (!match_held && seen_count >= len && window_hit(len)) begin
        match_held  = 1'b1;
        match_start = seen_count - COUNT_BITS'(len);
      end
    end
    report = '0;
    if (!last) return 1'b0;
    if (match_held) begin
      report.found = 1'b1;
      report.addr  = base_reg + ADDR_BITS'(match_start) + ADDR_BITS'(skip_after_wild(len));
    end
    clear_scan();
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte(logic narrow);
    logic [7:0] alphabet [4];
    alphabet = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    if (narrow) return alphabet[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  task automatic send_byte(logic [7:0] data, logic last, logic typed, scan_report_t typed_report);
    scan_report_t report;
    // idle at random, except for a stretch in the middle of the random part
    while ((bytes_sent < 600 || bytes_sent >= 850) && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (scan_byte(data, last, report)) pending_reports.push_back(typed ? typed_report : report);
  endtask

  // Hold the input until every pending result has left, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
  endtask

  task automatic send_region(logic brief, logic narrow);
    logic [7:0] region [$];
    int len;
    int size;
    int at;
    len = eff_len();
    if (brief) size = $urandom_range(1, 4);
    else begin
      case ($urandom_range(9))
        0:       size = $urandom_range(1, len);
        1:       size = len;
        9:       size = $urandom_range(30, 60);
        default: size = len + $urandom_range(0, 12);
      endcase
    end
    for (int i = 0; i < size; i++) region.push_back(pick_byte(narrow));
    // plant a pattern instance most of the time; wildcard slots keep random bytes
    if (size >= len && $urandom_range(9) < 7) begin
      at = $urandom_range(0, size - len);
      for (int j = 0; j < len; j++) begin
        if (!wild_bits[j]) region[at + j] = pat_byte(j);
      end
      if ($urandom_range(9) == 0) region[at + $urandom_range(0, len - 1)] ^= 8'h01;
    end
    foreach (region[i]) send_byte(region[i], i == region.size() - 1, 1'b0, '0);
  endtask

  task automatic write_random_config();
    logic [CFG_DATA_BITS-1:0] word;
    logic [CFG_DATA_BITS-1:0] mask_value;
    logic [CFG_DATA_BITS-1:0] len_value;
    logic [CFG_DATA_BITS-1:0] base_value;
    logic                     narrow;
    int                       run;
    narrow = 1'($urandom_range(1));
    for (int w = 0; w < 3; w++) begin
      for (int b = 0; b < 8; b++) word[b * 8 +: 8] = pick_byte(narrow);
      write_reg(w == 0 ? CFG_PAT_LOW : (w == 1 ? CFG_PAT_MID : CFG_PAT_HIGH), word);
    end
    case ($urandom_range(4))
      0: mask_value = '0;
      1: mask_value = '1;
      2: begin
        run = $urandom_range(1, 6);
        mask_value = ((64'd1 << run) - 1) << $urandom_range(0, 8);
      end
      default: mask_value = {$urandom, $urandom};
    endcase
    case ($urandom_range(6))
      0:       len_value = 64'd0;
      1:       len_value = 64'($urandom_range(MAX_PATTERN + 1, 31));
      2:       len_value = 64'(MAX_PATTERN);
      3:       len_value = 64'($urandom_range(9, MAX_PATTERN));
      default: len_value = 64'($urandom_range(1, 6));
    endcase
    case ($urandom_range(3))
      0:       base_value = '0;
      1:       base_value = '1;
      default: base_value = {$urandom, $urandom};
    endcase
    write_reg(CFG_WILD_MASK, mask_value);
    write_reg(CFG_PAT_LEN, len_value);
    write_reg(CFG_BASE, base_value);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected result", '0, 64'({out_tuser, out_tdata}));
      end else begin
        head_report = pending_reports.pop_front();
        if (out_tuser !== head_report.found) begin
          note_mismatch("match_found", 64'(head_report.found), 64'(out_tuser));
        end
        if (out_tdata !== head_report.addr) begin
          note_mismatch("match_address", 64'(head_report.addr), 64'(out_tdata));
        end
      end
    end
  end

  // Receiver: random stalls, one long hold on request, one stall-free stretch
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (reports_seen >= 50 && reports_seen < 75) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 29);
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int script_bytes;
    int phase;
    int regions;
    pat_words = '{default: '0};
    wild_bits = '0;
    len_reg   = LEN_BITS'(1);
    base_reg  = '0;
    clear_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_REG) begin
        if (r > 0 && script[r - 1].kind == ROW_BYTE) drain();
        write_reg(script[r].idx, script[r].value);
      end else begin
        if (r > 0 && script[r - 1].kind == ROW_REG) cfg_valid <= 1'b0;
        send_byte(script[r].data, script[r].last, script[r].typed,
                  scan_report_t'({script[r].exp_found, script[r].exp_addr}));
      end
    end
    cfg_valid <= 1'b0;
    script_bytes = bytes_sent;

    phase = 0;
    while (bytes_sent < script_bytes + RANDOM_BYTES) begin
      phase++;
      drain();
      write_random_config();
      cfg_valid <= 1'b0;
      // in one phase the receiver holds off while many short regions pile up
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      regions = (phase == HOLD_PHASE) ? 16 : $urandom_range(3, 10);
      repeat (regions) send_region(phase == HOLD_PHASE, 1'($urandom_range(1)));
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
